[rtl/calc_expression_tokenizer_core_defines.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef CALC_EXPRESSION_TOKENIZER_CORE_DEFINES_SVH
`define CALC_EXPRESSION_TOKENIZER_CORE_DEFINES_SVH

// Checked at every rising edge while out of reset.
`define CTOK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CTOK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ctok_pkg.sv]
// Package of the tokenizer: token codes, result types and byte classes.
package ctok_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int START_BITS = 16;
    localparam int TAG_BITS = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    localparam logic [TAG_BITS-1:0] TAG_EOI     = 4'd0;
    localparam logic [TAG_BITS-1:0] TAG_WITH    = 4'd1;
    localparam logic [TAG_BITS-1:0] TAG_IDENT   = 4'd2;
    localparam logic [TAG_BITS-1:0] TAG_NUMBER  = 4'd3;
    localparam logic [TAG_BITS-1:0] TAG_PLUS    = 4'd4;
    localparam logic [TAG_BITS-1:0] TAG_MINUS   = 4'd5;
    localparam logic [TAG_BITS-1:0] TAG_STAR    = 4'd6;
    localparam logic [TAG_BITS-1:0] TAG_SLASH   = 4'd7;
    localparam logic [TAG_BITS-1:0] TAG_LPAREN  = 4'd8;
    localparam logic [TAG_BITS-1:0] TAG_RPAREN  = 4'd9;
    localparam logic [TAG_BITS-1:0] TAG_COLON   = 4'd10;
    localparam logic [TAG_BITS-1:0] TAG_COMMA   = 4'd11;
    localparam logic [TAG_BITS-1:0] TAG_UNKNOWN = 4'd12;

    localparam logic [7:0] CH_END = 8'h00;

    typedef enum logic [2:0] {
        RUN_NONE   = 3'b001,
        RUN_LETTER = 3'b010,
        RUN_DIGIT  = 3'b100
    } run_kind_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [START_BITS-1:0] start;
        logic                  last;
    } result_t;

    // Up to two results produced by one byte, first in order first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [7:0] kw_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    kw_byte = 8'h77;
            2'd1:    kw_byte = 8'h69;
            2'd2:    kw_byte = 8'h74;
            default: kw_byte = 8'h68;
        endcase
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        is_decimal = (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c inside {8'h20, 8'h09, 8'h0C, 8'h0B, 8'h0D, 8'h0A});
    endfunction

    function automatic logic [TAG_BITS-1:0] punct_tag(input logic [7:0] c);
        case (c)
            8'h2B:   punct_tag = TAG_PLUS;
            8'h2D:   punct_tag = TAG_MINUS;
            8'h2A:   punct_tag = TAG_STAR;
            8'h2F:   punct_tag = TAG_SLASH;
            8'h28:   punct_tag = TAG_LPAREN;
            8'h29:   punct_tag = TAG_RPAREN;
            8'h3A:   punct_tag = TAG_COLON;
            8'h2C:   punct_tag = TAG_COMMA;
            default: punct_tag = TAG_UNKNOWN;
        endcase
    endfunction

endpackage

[rtl/ctok_lexer.sv]
// Lexer state and the classification of one byte into up to two tokens.
module ctok_lexer
    import ctok_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [7:0] ch,
    output push_t      push
);

    run_kind_t                run_kind_reg, run_kind_next;
    logic [POSITION_BITS-1:0] run_start_reg, run_start_next;
    logic [POSITION_BITS-1:0] char_position_reg, char_position_next;
    logic [2:0]               word_length_reg, word_length_next;
    logic                     kw_match_reg, kw_match_next;

    logic [START_BITS-1:0] here_tok;
    logic [START_BITS-1:0] run_start_tok;

    logic                run_emit;
    logic [TAG_BITS-1:0] run_tag;
    logic                byte_emit;
    logic [TAG_BITS-1:0] byte_tag;
    logic                end_seen;

    // Token positions are reported in sixteen bits; a wider position saturates there.
    generate
        if (POSITION_BITS > START_BITS) begin : g_sat
            assign here_tok = (|char_position_reg[POSITION_BITS-1:START_BITS])
                ? {START_BITS{1'b1}} : char_position_reg[START_BITS-1:0];
            assign run_start_tok = (|run_start_reg[POSITION_BITS-1:START_BITS])
                ? {START_BITS{1'b1}} : run_start_reg[START_BITS-1:0];
        end
        else begin : g_ext
            assign here_tok      = START_BITS'(char_position_reg);
            assign run_start_tok = START_BITS'(run_start_reg);
        end
    endgenerate

    // Returns the new {word_length, keyword match} after one more letter.
    function automatic logic [3:0] letter_advance(input logic [7:0] c,
                                                  input logic [2:0] wl,
                                                  input logic       kw);
        logic [2:0] wl_n;
        logic       kw_n;
        kw_n = kw;
        wl_n = wl;
        if (wl < 3'd4)
        begin
            if (c != kw_byte(wl[1:0]))
                kw_n = 1'b0;
        end
        else
        begin
            kw_n = 1'b0;
        end
        if (wl < 3'd7)
            wl_n = wl + 3'd1;
        letter_advance = {wl_n, kw_n};
    endfunction

    always_comb
    begin
        run_kind_next      = run_kind_reg;
        run_start_next     = run_start_reg;
        char_position_next = char_position_reg;
        word_length_next   = word_length_reg;
        kw_match_next      = kw_match_reg;
        run_emit           = 1'b0;
        run_tag            = TAG_IDENT;
        byte_emit          = 1'b0;
        byte_tag           = TAG_UNKNOWN;
        end_seen           = 1'b0;

        if (go)
        begin
            if (run_kind_reg == RUN_LETTER && is_letter(ch))
            begin
                {word_length_next, kw_match_next} =
                    letter_advance(ch, word_length_reg, kw_match_reg);
            end
            else if (run_kind_reg == RUN_DIGIT && is_decimal(ch))
            begin
                run_kind_next = RUN_DIGIT;
            end
            else
            begin
                if (run_kind_reg == RUN_LETTER)
                begin
                    run_emit = 1'b1;
                    run_tag  = (kw_match_reg && word_length_reg == 3'd4) ? TAG_WITH
                                                                           : TAG_IDENT;
                end
                else if (run_kind_reg == RUN_DIGIT)
                begin
                    run_emit = 1'b1;
                    run_tag  = TAG_NUMBER;
                end
                run_kind_next    = RUN_NONE;
                word_length_next = 3'd0;
                kw_match_next    = 1'b1;

                if (ch == CH_END)
                begin
                    byte_emit = 1'b1;
                    byte_tag  = TAG_EOI;
                    end_seen  = 1'b1;
                end
                else if (is_space(ch))
                begin
                    byte_emit = 1'b0;
                end
                else if (is_letter(ch))
                begin
                    run_kind_next  = RUN_LETTER;
                    run_start_next = char_position_reg;
                    {word_length_next, kw_match_next} = letter_advance(ch, 3'd0, 1'b1);
                end
                else if (is_decimal(ch))
                begin
                    run_kind_next  = RUN_DIGIT;
                    run_start_next = char_position_reg;
                end
                else
                begin
                    byte_emit = 1'b1;
                    byte_tag  = punct_tag(ch);
                end
            end

            // The end byte returns the whole lexer to its reset state.
            if (end_seen)
            begin
                run_start_next     = '0;
                char_position_next = '0;
            end
            else if (char_position_reg != {POSITION_BITS{1'b1}})
            begin
                char_position_next = char_position_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        push.count = {1'b0, run_emit} + {1'b0, byte_emit};
        if (run_emit)
        begin
            push.first.tag   = run_tag;
            push.first.start = run_start_tok;
            push.first.last  = !byte_emit;
        end
        else
        begin
            push.first.tag   = byte_tag;
            push.first.start = here_tok;
            push.first.last  = 1'b1;
        end
        push.second.tag   = byte_tag;
        push.second.start = here_tok;
        push.second.last  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg      <= RUN_NONE;
            run_start_reg     <= '0;
            char_position_reg <= '0;
            word_length_reg   <= 3'd0;
            kw_match_reg      <= 1'b1;
        end
        else
        begin
            run_kind_reg      <= run_kind_next;
            run_start_reg     <= run_start_next;
            char_position_reg <= char_position_next;
            word_length_reg   <= word_length_next;
            kw_match_reg      <= kw_match_next;
        end
    end

endmodule

[rtl/ctok_result_fifo.sv]
// Small result queue that takes up to two words a cycle and gives one.
module ctok_result_fifo
    import ctok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t head,
    output logic    not_empty,
    output logic    room_for_two
);

    // Depth is a power of two, so the pointers simply wrap.
    result_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] count_reg, count_next;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign head         = entry_reg[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_BITS'(pop);
        count_next  = count_reg + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/calc_expression_tokenizer_core.sv]
// Tokenizer top level: input register, lexer and result queue.
// One source byte is taken per cycle. A byte is held in an input register and,
// once the result queue has room for two words, the lexer classifies it and
// writes the zero, one or two tokens it causes into a four-word result queue,
// whose head is presented at the output. The sustained rate is one byte per
// cycle; input is held off only while the input register holds a byte and the
// queue has fewer than two free words, which happens when the output side
// stalls or when bytes cause two tokens each faster than the output takes them.
// Token positions count from zero after reset and after each zero byte, and
// saturate at the all-ones value of the position counter.
module calc_expression_tokenizer_core
    import ctok_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            ch,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TAG_BITS-1:0]   token_tag,
    output logic [START_BITS-1:0] token_start,
    output logic                  last_of_run
);

    logic       stage_valid_reg, stage_valid_next;
    logic [7:0] ch_reg;
    logic       accept;
    logic       go;
    logic       room_for_two;
    logic       pop;
    push_t      push;
    result_t    head;

    assign go       = stage_valid_reg && room_for_two;
    assign in_stall = stage_valid_reg && !room_for_two;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (go)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= ch;
    end

    ctok_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .ch    (ch_reg),
        .push  (push)
    );

    ctok_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (pop),
        .head         (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two)
    );

    assign token_tag   = head.tag;
    assign token_start = head.start;
    assign last_of_run = head.last;

endmodule

[rtl/ctok_checker.sv]
// Port-level checker for the tokenizer, bound to its top level.
`include "calc_expression_tokenizer_core_defines.svh"

module ctok_checker
    import ctok_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [TAG_BITS-1:0]   token_tag,
    input logic [START_BITS-1:0] token_start,
    input logic                  last_of_run
);

    `CTOK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!out_valid && !in_stall), "outputs active in reset")
    `CTOK_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(token_tag) && $stable(token_start) && $stable(last_of_run)), "stalled word changed")
    `CTOK_ASSERT(a_tag_range, out_valid |-> (token_tag <= TAG_UNKNOWN), "token tag out of range")
    `CTOK_ASSERT(a_eoi_last, (out_valid && token_tag == TAG_EOI) |-> last_of_run, "end token not last of its byte")

endmodule

bind calc_expression_tokenizer_core ctok_checker u_checker (.*);
